/* rtl/pfe_pkg.sv */
package pfe_pkg;

    // Palette geometry
    localparam int PALETTE_ENTRIES = 256;
    localparam int FADE_ENTRIES    = 80;
    localparam int FADE_CNT = (FADE_ENTRIES < PALETTE_ENTRIES) ? FADE_ENTRIES : PALETTE_ENTRIES;
    localparam int PAL_AW   = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int FADE_AW  = (FADE_CNT > 1) ? $clog2(FADE_CNT) : 1;

    // Field widths
    localparam int ACT_W = 3;
    localparam int IDX_W = 8;
    localparam int CH_W  = 6;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_WRITE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_READ     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SAVE     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FADE_OUT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FADE_IN  = 3'd4;

    // One palette word: red in the top bits, blue in the bottom
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    localparam int RGB_W = $bits(t_rgb);

    // Controller to datapath
    typedef struct packed {
        logic               in_ready;
        logic               item_wr;
        logic               item_rd;
        logic               sweep_rd;
        logic [FADE_AW-1:0] sweep_addr;
        logic               res_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             out_free;
    } t_status;

endpackage

/* rtl/pfe_if.sv */
// Input item channel
interface pfe_in_if;
    logic                       valid;
    logic                       ready;
    logic [pfe_pkg::ACT_W-1:0]  action;
    logic [pfe_pkg::IDX_W-1:0]  entry_index;
    logic [pfe_pkg::CH_W-1:0]   red_in;
    logic [pfe_pkg::CH_W-1:0]   green_in;
    logic [pfe_pkg::CH_W-1:0]   blue_in;

    modport source (output valid, action, entry_index, red_in, green_in, blue_in,
                    input ready);
    modport sink   (input valid, action, entry_index, red_in, green_in, blue_in,
                    output ready);
endinterface

// Result channel
interface pfe_out_if;
    logic                       valid;
    logic                       ready;
    logic [pfe_pkg::CH_W-1:0]   red_out;
    logic [pfe_pkg::CH_W-1:0]   green_out;
    logic [pfe_pkg::CH_W-1:0]   blue_out;
    logic                       settled;

    modport source (output valid, red_out, green_out, blue_out, settled, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, settled, output ready);
endinterface

/* rtl/pfe_ram.sv */
module pfe_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pfe_ctrl.sv */
module pfe_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  pfe_pkg::t_status i_status,
    output pfe_pkg::t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ISSUE  = 5'b00010,
        S_SWEEP  = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state                      r_state, n_state;
    logic [pfe_pkg::FADE_AW-1:0] r_cnt, n_cnt;
    logic                        last;
    logic                        is_sweep;

    assign last = (r_cnt == pfe_pkg::FADE_AW'(pfe_pkg::FADE_CNT - 1));

    // Save and both fades walk the faded range
    always_comb begin
        unique case (i_status.action) inside
            pfe_pkg::ACT_SAVE, pfe_pkg::ACT_FADE_OUT, pfe_pkg::ACT_FADE_IN: is_sweep = 1'b1;
            default: is_sweep = 1'b0;
        endcase
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.sweep_addr = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.item_wr = (i_status.action == pfe_pkg::ACT_WRITE);
                o_cmd.item_rd = (i_status.action == pfe_pkg::ACT_READ);
                n_cnt = '0;
                n_state = is_sweep ? S_SWEEP : S_RESULT;
            end
            S_SWEEP: begin
                o_cmd.sweep_rd = 1'b1;
                if (last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN: begin
                // final write-back happens in the datapath this cycle
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt <= n_cnt;
    end

endmodule

/* rtl/pfe_datapath.sv */
module pfe_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pfe_pkg::t_cmd               i_cmd,
    output pfe_pkg::t_status            o_status,
    input  logic                        i_accept,
    input  logic [pfe_pkg::ACT_W-1:0]   i_action,
    input  logic [pfe_pkg::IDX_W-1:0]   i_entry_index,
    input  logic [pfe_pkg::CH_W-1:0]    i_red_in,
    input  logic [pfe_pkg::CH_W-1:0]    i_green_in,
    input  logic [pfe_pkg::CH_W-1:0]    i_blue_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [pfe_pkg::CH_W-1:0]    o_red_out,
    output logic [pfe_pkg::CH_W-1:0]    o_green_out,
    output logic [pfe_pkg::CH_W-1:0]    o_blue_out,
    output logic                        o_settled
);

    // One channel of a fade step: {changed, new value}
    function automatic logic [pfe_pkg::CH_W:0] fade_ch(
        input logic [pfe_pkg::CH_W-1:0] cur,
        input logic [pfe_pkg::CH_W-1:0] tgt,
        input logic                     up
    );
        logic [pfe_pkg::CH_W:0] res;
        res = {1'b0, cur};
        if (up) begin
            if (cur < tgt) begin
                res = {1'b1, cur + 1'b1};
            end
        end else if (cur != '0) begin
            res = {1'b1, cur - 1'b1};
        end
        return res;
    endfunction

    logic [pfe_pkg::ACT_W-1:0]  r_action;
    logic [pfe_pkg::IDX_W-1:0]  r_idx;
    pfe_pkg::t_rgb              r_item_rgb;
    logic                       idx_ok;
    logic [pfe_pkg::PAL_AW-1:0] item_addr;

    logic                       pal_we, pal_re;
    logic [pfe_pkg::PAL_AW-1:0] pal_waddr, pal_raddr;
    pfe_pkg::t_rgb              pal_wdata, pal_rdata, pal_word;
    logic [pfe_pkg::PALETTE_ENTRIES-1:0] r_pal_vld;
    logic                       r_rd_vld;

    logic                       tgt_we;
    pfe_pkg::t_rgb              tgt_rdata;

    logic                        r_wb_pend;
    logic [pfe_pkg::FADE_AW-1:0] r_wb_addr;
    logic                        is_fade, fade_up;
    logic [pfe_pkg::CH_W:0]      fr, fg, fb;
    pfe_pkg::t_rgb               wb_rgb;
    logic                        r_changed;

    logic                        r_out_valid;
    pfe_pkg::t_rgb               r_out_rgb;
    logic                        r_settled;

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_action   <= i_action;
            r_idx      <= i_entry_index;
            r_item_rgb <= '{red: i_red_in, green: i_green_in, blue: i_blue_in};
        end
    end

    assign idx_ok    = (32'(r_idx) < 32'(pfe_pkg::PALETTE_ENTRIES));
    assign item_addr = r_idx[pfe_pkg::PAL_AW-1:0];
    assign fade_up   = (r_action == pfe_pkg::ACT_FADE_IN);
    assign is_fade   = (r_action == pfe_pkg::ACT_FADE_OUT) || fade_up;

    // Entries never written read as zero
    assign pal_word = r_rd_vld ? pal_rdata : '0;

    // Fade arithmetic on the entry read last cycle
    always_comb begin
        fr = fade_ch(pal_word.red,   tgt_rdata.red,   fade_up);
        fg = fade_ch(pal_word.green, tgt_rdata.green, fade_up);
        fb = fade_ch(pal_word.blue,  tgt_rdata.blue,  fade_up);
        wb_rgb = '{red:   fr[pfe_pkg::CH_W-1:0],
                   green: fg[pfe_pkg::CH_W-1:0],
                   blue:  fb[pfe_pkg::CH_W-1:0]};
    end

    // Palette port selection: item or sweep read, item write or sweep write-back
    always_comb begin
        pal_re    = (i_cmd.item_rd && idx_ok) || i_cmd.sweep_rd;
        pal_raddr = i_cmd.sweep_rd ? pfe_pkg::PAL_AW'(i_cmd.sweep_addr) : item_addr;
        if (r_wb_pend) begin
            pal_we    = is_fade;
            pal_waddr = pfe_pkg::PAL_AW'(r_wb_addr);
            pal_wdata = wb_rgb;
        end else begin
            pal_we    = i_cmd.item_wr && idx_ok;
            pal_waddr = item_addr;
            pal_wdata = r_item_rgb;
        end
    end

    assign tgt_we = r_wb_pend && (r_action == pfe_pkg::ACT_SAVE);

    pfe_ram #(.WIDTH(pfe_pkg::RGB_W), .DEPTH(pfe_pkg::PALETTE_ENTRIES)) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (pal_waddr),
        .i_wdata (pal_wdata),
        .i_re    (pal_re),
        .i_raddr (pal_raddr),
        .o_rdata (pal_rdata)
    );

    pfe_ram #(.WIDTH(pfe_pkg::RGB_W), .DEPTH(pfe_pkg::FADE_CNT)) u_tgt_ram (
        .i_clk   (i_clk),
        .i_we    (tgt_we),
        .i_waddr (r_wb_addr),
        .i_wdata (pal_word),
        .i_re    (i_cmd.sweep_rd),
        .i_raddr (i_cmd.sweep_addr),
        .o_rdata (tgt_rdata)
    );

    // Per-entry written flags stand in for the palette's zero reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_vld <= '0;
        end else if (pal_we) begin
            r_pal_vld[pal_waddr] <= 1'b1;
        end
        if (pal_re) begin
            r_rd_vld <= r_pal_vld[pal_raddr];
        end
    end

    // Write-back stage follows the sweep read in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_pend <= 1'b0;
        end else begin
            r_wb_pend <= i_cmd.sweep_rd;
        end
        r_wb_addr <= i_cmd.sweep_addr;
    end

    // Any channel moved during this step
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_changed <= 1'b0;
        end else if (r_wb_pend && is_fade) begin
            r_changed <= r_changed | fr[pfe_pkg::CH_W] | fg[pfe_pkg::CH_W] | fb[pfe_pkg::CH_W];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.res_load) begin
            r_out_rgb <= ((r_action == pfe_pkg::ACT_READ) && idx_ok) ? pal_word : '0;
            r_settled <= is_fade && !r_changed;
        end
    end

    assign o_status.action   = r_action;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_red_out   = r_out_rgb.red;
    assign o_green_out = r_out_rgb.green;
    assign o_blue_out  = r_out_rgb.blue;
    assign o_settled   = r_settled;

endmodule

/* rtl/palette_fade_engine.sv */
// Channel    Dir  Payload                                       Transfer
// i_item     in   action, entry_index, red_in, green_in,        valid & ready
//                 blue_in
// o_result   out  red_out, green_out, blue_out, settled         valid & ready
//
// Write, read and unused actions go from the issue state to the result state.
// Save and fade steps sweep the first FADE_CNT entries, then drain: one palette RAM
// read and one write-back per faded entry, pipelined one entry per cycle.
// One item is in work at a time; a finished result sits in the output
// register so the next item can transfer while it waits.
// Reset is synchronous, active low; it clears the palette written flags.
// A stalled result only holds the engine once the next result is ready.
module palette_fade_engine (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfe_in_if.sink    i_item,
    pfe_out_if.source o_result
);

    pfe_pkg::t_cmd    cmd;
    pfe_pkg::t_status status;
    logic             accept;

    assign i_item.ready = cmd.in_ready;
    assign accept       = i_item.valid && cmd.in_ready;

    pfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pfe_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_accept      (accept),
        .i_action      (i_item.action),
        .i_entry_index (i_item.entry_index),
        .i_red_in      (i_item.red_in),
        .i_green_in    (i_item.green_in),
        .i_blue_in     (i_item.blue_in),
        .o_out_valid   (o_result.valid),
        .i_out_ready   (o_result.ready),
        .o_red_out     (o_result.red_out),
        .o_green_out   (o_result.green_out),
        .o_blue_out    (o_result.blue_out),
        .o_settled     (o_result.settled)
    );

endmodule

/* rtl/pfe_checker.sv */
module pfe_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [pfe_pkg::CH_W-1:0]  i_red_out,
    input logic [pfe_pkg::CH_W-1:0]  i_green_out,
    input logic [pfe_pkg::CH_W-1:0]  i_blue_out,
    input logic                      i_settled
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_red_out)
            && $stable(i_green_out) && $stable(i_blue_out) && $stable(i_settled))
        else $error("result changed while stalled");

    // One item at a time: no transfer right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a transfer");

    // No result can appear the cycle after a transfer
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> !i_out_valid)
        else $error("result too early");

    // Only fade steps report settled, and they carry no color
    a_settled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_settled |-> i_red_out == '0 && i_green_out == '0
            && i_blue_out == '0)
        else $error("settled result carries color");

endmodule

bind palette_fade_engine pfe_checker u_pfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_red_out   (o_result.red_out),
    .i_green_out (o_result.green_out),
    .i_blue_out  (o_result.blue_out),
    .i_settled   (o_result.settled)
);
